// File: sv/road_horizon_walker_assert.svh
// ----------------------------------------------------------------------------
// Road horizon walker assertion macros
// Shorthand for the concurrent checks used on the horizon walker.
// ----------------------------------------------------------------------------
`ifndef ROAD_HORIZON_WALKER_ASSERT_SVH
`define ROAD_HORIZON_WALKER_ASSERT_SVH

// same-cycle implication
`define RHW_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("horizon walker check failed");

// next-cycle implication, active during reset too
`define RHW_ASSERT_NXT(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("horizon walker check failed");

`endif

// File: sv/rhw_pkg.sv
// ----------------------------------------------------------------------------
// Road horizon walker package
// Shared widths, request codes, queue item type and default sizes.
// ----------------------------------------------------------------------------
package rhw_pkg;

  localparam int IDX_W  = 13;
  localparam int NODE_W = 12;
  localparam int SEG_W  = 12;
  localparam int DIST_W = 32;
  localparam int CNT_W  = 4;

  localparam int SEGMENT_SLOTS_DEF = 4096;
  localparam int NODE_SLOTS_DEF    = 4096;
  localparam int EDGE_SLOTS_DEF    = 8192;
  localparam int MAX_DEGREE_DEF    = 8;
  localparam int MAX_STEPS_DEF     = 63;

  localparam logic [DIST_W-1:0] LOOKAHEAD_RESET = 32'd200000;

  localparam logic [1:0] REQ_SEGMENT = 2'd0;
  localparam logic [1:0] REQ_NODE    = 2'd1;
  localparam logic [1:0] REQ_EDGE    = 2'd2;
  localparam logic [1:0] REQ_QUERY   = 2'd3;

  typedef struct packed {
    logic [1:0]        req;
    logic [IDX_W-1:0]  idx;
    logic              ok;
    logic [DIST_W-1:0] length;
    logic [31:0]       ident;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic [IDX_W-1:0]  first_edge;
    logic [CNT_W-1:0]  edge_count;
    logic [SEG_W-1:0]  link_segment;
    logic              fwd;
    logic [DIST_W-1:0] offset;
  } item_t;

endpackage

// File: sv/road_horizon_walker.sv
// ----------------------------------------------------------------------------
// Road horizon walker
// Road graph tables and a walker that reports the runs ahead of a vehicle.
// ----------------------------------------------------------------------------
//  channel   | handshake                | payload
//  ----------+--------------------------+------------------------------------
//  request   | start, busy              | req_type .. offset_cm
//  result    | result_valid (strobe)    | run_segment .. last_run
//  config    | cfg_we                   | cfg_wdata (lookahead_cm)
//
//  A two-beat queue sits between front and back; busy is high while it is full.
//  The back end pops a write beat and writes it if its index is in range. A
//  query runs the first and check states, then node, scan, decide and next
//  for each follow-on run. Synchronous reset clears control only; tables hold
//  nothing defined until written. Results cannot be stalled.
// ----------------------------------------------------------------------------
module road_horizon_walker #(
  parameter int SEGMENT_SLOTS = rhw_pkg::SEGMENT_SLOTS_DEF,
  parameter int NODE_SLOTS    = rhw_pkg::NODE_SLOTS_DEF,
  parameter int EDGE_SLOTS    = rhw_pkg::EDGE_SLOTS_DEF,
  parameter int MAX_DEGREE    = rhw_pkg::MAX_DEGREE_DEF,
  parameter int MAX_STEPS     = rhw_pkg::MAX_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rhw_pkg::DIST_W-1:0]  cfg_wdata,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  req_type,
  input  logic [rhw_pkg::IDX_W-1:0]   entry_index,
  input  logic [rhw_pkg::DIST_W-1:0]  length_cm,
  input  logic [31:0]                 ident,
  input  logic [rhw_pkg::NODE_W-1:0]  from_node,
  input  logic [rhw_pkg::NODE_W-1:0]  to_node,
  input  logic [rhw_pkg::IDX_W-1:0]   first_edge,
  input  logic [rhw_pkg::CNT_W-1:0]   edge_count,
  input  logic [rhw_pkg::SEG_W-1:0]   link_segment,
  input  logic                        direction_forward,
  input  logic [rhw_pkg::DIST_W-1:0]  offset_cm,
  output logic                        result_valid,
  output logic [rhw_pkg::SEG_W-1:0]   run_segment,
  output logic [31:0]                 run_ident,
  output logic [rhw_pkg::DIST_W-1:0]  run_start_cm,
  output logic [rhw_pkg::DIST_W-1:0]  run_end_cm,
  output logic                        run_forward,
  output logic                        empty_horizon,
  output logic                        last_run
);
  import rhw_pkg::*;

  item_t head;
  logic  head_valid;
  logic  pop;

  rhw_front #(
    .SEGMENT_SLOTS(SEGMENT_SLOTS),
    .NODE_SLOTS   (NODE_SLOTS),
    .EDGE_SLOTS   (EDGE_SLOTS)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .req_type         (req_type),
    .entry_index      (entry_index),
    .length_cm        (length_cm),
    .ident            (ident),
    .from_node        (from_node),
    .to_node          (to_node),
    .first_edge       (first_edge),
    .edge_count       (edge_count),
    .link_segment     (link_segment),
    .direction_forward(direction_forward),
    .offset_cm        (offset_cm),
    .busy             (busy),
    .head             (head),
    .head_valid       (head_valid),
    .pop              (pop)
  );

  rhw_back #(
    .SEGMENT_SLOTS(SEGMENT_SLOTS),
    .NODE_SLOTS   (NODE_SLOTS),
    .EDGE_SLOTS   (EDGE_SLOTS),
    .MAX_DEGREE   (MAX_DEGREE),
    .MAX_STEPS    (MAX_STEPS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .result_valid (result_valid),
    .run_segment  (run_segment),
    .run_ident    (run_ident),
    .run_start_cm (run_start_cm),
    .run_end_cm   (run_end_cm),
    .run_forward  (run_forward),
    .empty_horizon(empty_horizon),
    .last_run     (last_run)
  );

endmodule

// File: sv/rhw_front.sv
// ----------------------------------------------------------------------------
// Horizon walker front end
// Accepts request beats, checks the index against its table, queues them.
// ----------------------------------------------------------------------------
module rhw_front #(
  parameter int SEGMENT_SLOTS = rhw_pkg::SEGMENT_SLOTS_DEF,
  parameter int NODE_SLOTS    = rhw_pkg::NODE_SLOTS_DEF,
  parameter int EDGE_SLOTS    = rhw_pkg::EDGE_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [1:0]                  req_type,
  input  logic [rhw_pkg::IDX_W-1:0]   entry_index,
  input  logic [rhw_pkg::DIST_W-1:0]  length_cm,
  input  logic [31:0]                 ident,
  input  logic [rhw_pkg::NODE_W-1:0]  from_node,
  input  logic [rhw_pkg::NODE_W-1:0]  to_node,
  input  logic [rhw_pkg::IDX_W-1:0]   first_edge,
  input  logic [rhw_pkg::CNT_W-1:0]   edge_count,
  input  logic [rhw_pkg::SEG_W-1:0]   link_segment,
  input  logic                        direction_forward,
  input  logic [rhw_pkg::DIST_W-1:0]  offset_cm,
  output logic                        busy,
  output rhw_pkg::item_t              head,
  output logic                        head_valid,
  input  logic                        pop
);
  import rhw_pkg::*;

  item_t       q [2];
  item_t       in_item;
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic [31:0] idx32;
  logic        in_ok;

  assign idx32 = 32'(entry_index);

  always_comb begin
    case (req_type)
      REQ_NODE: in_ok = idx32 < 32'(NODE_SLOTS);
      REQ_EDGE: in_ok = idx32 < 32'(EDGE_SLOTS);
      default:  in_ok = idx32 < 32'(SEGMENT_SLOTS);
    endcase
  end

  always_comb begin
    in_item.req          = req_type;
    in_item.idx          = entry_index;
    in_item.ok           = in_ok;
    in_item.length       = length_cm;
    in_item.ident        = ident;
    in_item.from_node    = from_node;
    in_item.to_node      = to_node;
    in_item.first_edge   = first_edge;
    in_item.edge_count   = edge_count;
    in_item.link_segment = link_segment;
    in_item.fwd          = direction_forward;
    in_item.offset       = offset_cm;
  end

  assign busy       = count == 2'd2;
  assign push       = start && !busy;
  assign head       = q[rd_ptr];
  assign head_valid = count != 2'd0;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: sv/rhw_back.sv
// ----------------------------------------------------------------------------
// Horizon walker back end
// Owns the graph tables, executes writes and walks the road for queries.
// ----------------------------------------------------------------------------
module rhw_back #(
  parameter int SEGMENT_SLOTS = rhw_pkg::SEGMENT_SLOTS_DEF,
  parameter int NODE_SLOTS    = rhw_pkg::NODE_SLOTS_DEF,
  parameter int EDGE_SLOTS    = rhw_pkg::EDGE_SLOTS_DEF,
  parameter int MAX_DEGREE    = rhw_pkg::MAX_DEGREE_DEF,
  parameter int MAX_STEPS     = rhw_pkg::MAX_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rhw_pkg::DIST_W-1:0]  cfg_wdata,
  input  rhw_pkg::item_t              head,
  input  logic                        head_valid,
  output logic                        pop,
  output logic                        result_valid,
  output logic [rhw_pkg::SEG_W-1:0]   run_segment,
  output logic [31:0]                 run_ident,
  output logic [rhw_pkg::DIST_W-1:0]  run_start_cm,
  output logic [rhw_pkg::DIST_W-1:0]  run_end_cm,
  output logic                        run_forward,
  output logic                        empty_horizon,
  output logic                        last_run
);
  import rhw_pkg::*;

  localparam int SEG_AW  = $clog2(SEGMENT_SLOTS);
  localparam int NODE_AW = $clog2(NODE_SLOTS);
  localparam int EDGE_AW = $clog2(EDGE_SLOTS);
  localparam int STEP_W  = $clog2(MAX_STEPS + 1);
  localparam int E_W     = IDX_W + 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FIRST  = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_NODE   = 3'd3;
  localparam logic [2:0] ST_SCAN   = 3'd4;
  localparam logic [2:0] ST_DECIDE = 3'd5;
  localparam logic [2:0] ST_NEXT   = 3'd6;

  // tables
  logic [DIST_W-1:0] seg_len  [SEGMENT_SLOTS];
  logic [31:0]       seg_id   [SEGMENT_SLOTS];
  logic [NODE_W-1:0] seg_sn   [SEGMENT_SLOTS];
  logic [NODE_W-1:0] seg_en   [SEGMENT_SLOTS];
  logic [IDX_W-1:0]  node_base[NODE_SLOTS];
  logic [CNT_W-1:0]  node_cnt [NODE_SLOTS];
  logic [SEG_W-1:0]  edge_seg [EDGE_SLOTS];
  logic [NODE_W-1:0] edge_tgt [EDGE_SLOTS];
  logic              edge_dir [EDGE_SLOTS];

  logic [DIST_W-1:0] seg_len_q;
  logic [31:0]       seg_id_q;
  logic [NODE_W-1:0] seg_sn_q;
  logic [NODE_W-1:0] seg_en_q;
  logic [IDX_W-1:0]  node_base_q;
  logic [CNT_W-1:0]  node_cnt_q;
  logic [SEG_W-1:0]  edge_seg_q;
  logic [NODE_W-1:0] edge_tgt_q;
  logic              edge_dir_q;

  logic [2:0]        state;
  logic [DIST_W-1:0] lookahead;
  logic [DIST_W-1:0] total;
  logic [NODE_W-1:0] at;
  logic [IDX_W-1:0]  prev;
  logic [IDX_W-1:0]  q_idx;
  logic              q_fwd;
  logic [DIST_W-1:0] q_off;
  logic [STEP_W-1:0] step;
  logic [IDX_W-1:0]  base;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  k;
  logic              edge_v;
  logic [1:0]        choices;
  logic [SEG_W-1:0]  pick_seg;
  logic [NODE_W-1:0] pick_tgt;
  logic              pick_dir;
  logic [SEG_W-1:0]  p_seg;
  logic [31:0]       p_ident;
  logic [DIST_W-1:0] p_start;
  logic [DIST_W-1:0] p_end;
  logic              p_fwd;

  logic              start_q;
  logic              seg_we, node_we, edge_we;
  logic              seg_re, node_re, edge_re;
  logic [SEG_AW-1:0] seg_raddr;
  logic [E_W-1:0]    e;
  logic              e_ok;
  logic              go_next;
  logic [DIST_W-1:0] off_c, ahead, first_tot;
  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] sum_c;
  logic [CNT_W-1:0]  cnt_c;

  assign start_q = state == ST_IDLE && head_valid;
  assign pop     = start_q;
  assign seg_we  = start_q && head.ok && head.req == REQ_SEGMENT;
  assign node_we = start_q && head.ok && head.req == REQ_NODE;
  assign edge_we = start_q && head.ok && head.req == REQ_EDGE;

  assign e    = E_W'(base) + E_W'(k);
  assign e_ok = 32'(e) < 32'(EDGE_SLOTS);

  assign go_next = choices == 2'd1 && 32'(pick_seg) < 32'(SEGMENT_SLOTS);

  assign seg_re  = (start_q && head.ok && head.req == REQ_QUERY) ||
                   (state == ST_DECIDE && go_next);
  assign seg_raddr = (state == ST_IDLE) ? SEG_AW'(head.idx) : SEG_AW'(pick_seg);
  assign node_re = state == ST_CHECK;
  assign edge_re = state == ST_SCAN && k < cnt && e_ok;

  assign off_c     = (q_off > seg_len_q) ? seg_len_q : q_off;
  assign ahead     = q_fwd ? seg_len_q - off_c : off_c;
  assign first_tot = (ahead < lookahead) ? ahead : lookahead;
  assign sum       = {1'b0, total} + {1'b0, seg_len_q};
  assign sum_c     = (sum > {1'b0, lookahead}) ? lookahead : sum[DIST_W-1:0];
  assign cnt_c     = (32'(node_cnt_q) > 32'(MAX_DEGREE)) ? CNT_W'(MAX_DEGREE)
                                                         : node_cnt_q;

  always_ff @(posedge clk) begin
    if (seg_we) begin
      seg_len[SEG_AW'(head.idx)] <= head.length;
      seg_id[SEG_AW'(head.idx)]  <= head.ident;
      seg_sn[SEG_AW'(head.idx)]  <= head.from_node;
      seg_en[SEG_AW'(head.idx)]  <= head.to_node;
    end
    if (seg_re) begin
      seg_len_q <= seg_len[seg_raddr];
      seg_id_q  <= seg_id[seg_raddr];
      seg_sn_q  <= seg_sn[seg_raddr];
      seg_en_q  <= seg_en[seg_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_base[NODE_AW'(head.idx)] <= head.first_edge;
      node_cnt[NODE_AW'(head.idx)]  <= head.edge_count;
    end
    if (node_re) begin
      node_base_q <= node_base[NODE_AW'(at)];
      node_cnt_q  <= node_cnt[NODE_AW'(at)];
    end
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_seg[EDGE_AW'(head.idx)] <= head.link_segment;
      edge_tgt[EDGE_AW'(head.idx)] <= head.to_node;
      edge_dir[EDGE_AW'(head.idx)] <= head.fwd;
    end
    if (edge_re) begin
      edge_seg_q <= edge_seg[EDGE_AW'(e)];
      edge_tgt_q <= edge_tgt[EDGE_AW'(e)];
      edge_dir_q <= edge_dir[EDGE_AW'(e)];
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (start_q) begin
      q_idx <= head.idx;
      q_fwd <= head.fwd;
      q_off <= head.offset;
    end
    case (state)
      ST_FIRST: begin
        total   <= first_tot;
        at      <= q_fwd ? seg_en_q : seg_sn_q;
        prev    <= q_idx;
        p_seg   <= SEG_W'(q_idx);
        p_ident <= seg_id_q;
        p_start <= '0;
        p_end   <= first_tot;
        p_fwd   <= q_fwd;
      end
      ST_NODE: begin
        base    <= node_base_q;
        cnt     <= cnt_c;
        k       <= '0;
        edge_v  <= 1'b0;
        choices <= 2'd0;
      end
      ST_SCAN: begin
        if (k < cnt) begin
          k      <= k + 1'b1;
          edge_v <= e_ok;
        end else begin
          edge_v <= 1'b0;
        end
        if (edge_v && IDX_W'(edge_seg_q) != prev) begin
          choices  <= (choices == 2'd2) ? 2'd2 : choices + 2'd1;
          pick_seg <= edge_seg_q;
          pick_tgt <= edge_tgt_q;
          pick_dir <= edge_dir_q;
        end
      end
      ST_NEXT: begin
        total   <= sum_c;
        prev    <= IDX_W'(pick_seg);
        at      <= pick_tgt;
        p_seg   <= pick_seg;
        p_ident <= seg_id_q;
        p_start <= total;
        p_end   <= sum_c;
        p_fwd   <= pick_dir;
      end
      default: begin
      end
    endcase
  end

  // control and result beats
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      lookahead    <= LOOKAHEAD_RESET;
      result_valid <= 1'b0;
      step         <= '0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_we) begin
        lookahead <= cfg_wdata;
      end
      case (state)
        ST_IDLE: begin
          if (start_q && head.req == REQ_QUERY) begin
            if (head.ok) begin
              state <= ST_FIRST;
            end else begin
              result_valid  <= 1'b1;
              run_segment   <= '0;
              run_ident     <= '0;
              run_start_cm  <= '0;
              run_end_cm    <= '0;
              run_forward   <= 1'b0;
              empty_horizon <= 1'b1;
              last_run      <= 1'b1;
            end
          end
        end
        ST_FIRST: begin
          step  <= '0;
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (32'(step) >= 32'(MAX_STEPS) || total >= lookahead ||
              32'(at) >= 32'(NODE_SLOTS)) begin
            result_valid  <= 1'b1;
            run_segment   <= p_seg;
            run_ident     <= p_ident;
            run_start_cm  <= p_start;
            run_end_cm    <= p_end;
            run_forward   <= p_fwd;
            empty_horizon <= 1'b0;
            last_run      <= 1'b1;
            state         <= ST_IDLE;
          end else begin
            state <= ST_NODE;
          end
        end
        ST_NODE: state <= ST_SCAN;
        ST_SCAN: begin
          if (!(k < cnt) && !edge_v) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (go_next) begin
            state <= ST_NEXT;
          end else begin
            result_valid  <= 1'b1;
            run_segment   <= p_seg;
            run_ident     <= p_ident;
            run_start_cm  <= p_start;
            run_end_cm    <= p_end;
            run_forward   <= p_fwd;
            empty_horizon <= 1'b0;
            last_run      <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        ST_NEXT: begin
          result_valid  <= 1'b1;
          run_segment   <= p_seg;
          run_ident     <= p_ident;
          run_start_cm  <= p_start;
          run_end_cm    <= p_end;
          run_forward   <= p_fwd;
          empty_horizon <= 1'b0;
          last_run      <= 1'b0;
          step          <= step + 1'b1;
          state         <= ST_CHECK;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: sv/rhw_checker.sv
// ----------------------------------------------------------------------------
// Horizon walker port checker
// Checks result beats seen on the top-level ports; bound to the top level.
// ----------------------------------------------------------------------------
`include "road_horizon_walker_assert.svh"

module rhw_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic [11:0] run_segment,
  input logic [31:0] run_start_cm,
  input logic [31:0] run_end_cm,
  input logic        empty_horizon,
  input logic        last_run
);

  `RHW_ASSERT_IMP(a_empty_last, clk, rst, result_valid && empty_horizon, last_run)
  `RHW_ASSERT_IMP(a_empty_zero, clk, rst, result_valid && empty_horizon, run_segment == 12'd0 && run_end_cm == 32'd0)
  `RHW_ASSERT_IMP(a_run_order, clk, rst, result_valid && !empty_horizon, run_start_cm <= run_end_cm)
  `RHW_ASSERT_NXT(a_reset_quiet, clk, rst, !result_valid)

endmodule

bind road_horizon_walker rhw_checker u_rhw_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .run_segment  (run_segment),
  .run_start_cm (run_start_cm),
  .run_end_cm   (run_end_cm),
  .empty_horizon(empty_horizon),
  .last_run     (last_run)
);

// File: tb/rhw_horizon_checker.sv
// ----------------------------------------------------------------------------
// Road horizon walker checker
// Keeps a shadow copy of the road graph tables and of the lookahead register
// by watching accepted request beats and register writes. For each accepted
// query it walks the shadow graph and queues the runs it should produce, then
// compares every result strobe field by field against the oldest queued run.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rhw_horizon_checker
  import rhw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [DIST_W-1:0] cfg_wdata,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        req_type,
  input  logic [IDX_W-1:0]  entry_index,
  input  logic [DIST_W-1:0] length_cm,
  input  logic [31:0]       ident,
  input  logic [NODE_W-1:0] from_node,
  input  logic [NODE_W-1:0] to_node,
  input  logic [IDX_W-1:0]  first_edge,
  input  logic [CNT_W-1:0]  edge_count,
  input  logic [SEG_W-1:0]  link_segment,
  input  logic              direction_forward,
  input  logic [DIST_W-1:0] offset_cm,
  input  logic              result_valid,
  input  logic [SEG_W-1:0]  run_segment,
  input  logic [31:0]       run_ident,
  input  logic [DIST_W-1:0] run_start_cm,
  input  logic [DIST_W-1:0] run_end_cm,
  input  logic              run_forward,
  input  logic              empty_horizon,
  input  logic              last_run,
  output int                mismatches,
  output int                outstanding
);

  typedef struct {
    logic [SEG_W-1:0]  seg;
    logic [31:0]       ident;
    logic [DIST_W-1:0] from_cm;
    logic [DIST_W-1:0] to_cm;
    logic              fwd;
    logic              empty;
    logic              last;
  } run_t;

  logic [DIST_W-1:0] seg_len   [SEGMENT_SLOTS_DEF];
  logic [31:0]       seg_ident [SEGMENT_SLOTS_DEF];
  logic [NODE_W-1:0] seg_from  [SEGMENT_SLOTS_DEF];
  logic [NODE_W-1:0] seg_to    [SEGMENT_SLOTS_DEF];
  logic [IDX_W-1:0]  node_base [NODE_SLOTS_DEF];
  logic [CNT_W-1:0]  node_cnt  [NODE_SLOTS_DEF];
  logic [SEG_W-1:0]  edge_seg  [EDGE_SLOTS_DEF];
  logic [NODE_W-1:0] edge_tgt  [EDGE_SLOTS_DEF];
  logic              edge_fwd  [EDGE_SLOTS_DEF];

  logic [DIST_W-1:0] look_cm;
  run_t              runs_due[$];
  run_t              held;
  bit                have_held;

  initial mismatches = 0;
  initial outstanding = 0;

  function automatic run_t make_run(int seg, logic [31:0] from_cm, logic [31:0] to_cm,
                                    logic fwd);
    run_t r;
    r.seg = seg[SEG_W-1:0];
    r.ident = seg_ident[seg];
    r.from_cm = from_cm;
    r.to_cm = to_cm;
    r.fwd = fwd;
    r.empty = 1'b0;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic hold_run(run_t r);
    if (have_held) runs_due = {runs_due, held};
    held = r;
    have_held = 1;
  endtask

  task automatic trace_horizon(logic [IDX_W-1:0] idx, logic fwd, logic [DIST_W-1:0] off);
    logic [DIST_W-1:0] len, ahead, total;
    logic [63:0]       sum;
    int                at, prev, base, cnt, e, pick, choices, nseg;
    run_t              r;
    have_held = 0;
    if (idx >= SEGMENT_SLOTS_DEF) begin
      r = '{seg: '0, ident: '0, from_cm: '0, to_cm: '0, fwd: 1'b0, empty: 1'b1, last: 1'b1};
      runs_due = {runs_due, r};
      return;
    end
    len = seg_len[idx[SEG_W-1:0]];
    if (off > len) off = len;
    ahead = fwd ? len - off : off;
    total = (ahead < look_cm) ? ahead : look_cm;
    hold_run(make_run(int'(idx), '0, total, fwd));
    at = fwd ? int'(seg_to[idx[SEG_W-1:0]]) : int'(seg_from[idx[SEG_W-1:0]]);
    prev = int'(idx);
    for (int step = 0; step < MAX_STEPS_DEF && total < look_cm; step++) begin
      base = int'(node_base[at]);
      cnt = int'(node_cnt[at]);
      if (cnt > MAX_DEGREE_DEF) cnt = MAX_DEGREE_DEF;
      choices = 0;
      pick = 0;
      for (int k = 0; k < cnt; k++) begin
        e = base + k;
        if (e >= EDGE_SLOTS_DEF) continue;
        if (int'(edge_seg[e]) == prev) continue;
        choices++;
        pick = e;
      end
      if (choices != 1) break;
      nseg = int'(edge_seg[pick]);
      sum = {32'd0, total} + {32'd0, seg_len[nseg]};
      if (sum > {32'd0, look_cm}) sum = {32'd0, look_cm};
      hold_run(make_run(nseg, total, sum[31:0], edge_fwd[pick]));
      total = sum[31:0];
      prev = nseg;
      at = int'(edge_tgt[pick]);
    end
    held.last = 1'b1;
    runs_due = {runs_due, held};
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    run_t r;
    if (rst) begin
      runs_due.delete();
      look_cm = LOOKAHEAD_RESET;
    end else begin
      if (result_valid) begin
        if (runs_due.size() == 0) begin
          $error("result beat with no run expected");
          mismatches++;
        end else begin
          r = runs_due.pop_front();
          check_field("run_segment", 32'(r.seg), 32'(run_segment));
          check_field("run_ident", r.ident, run_ident);
          check_field("run_start_cm", r.from_cm, run_start_cm);
          check_field("run_end_cm", r.to_cm, run_end_cm);
          check_field("run_forward", 32'(r.fwd), 32'(run_forward));
          check_field("empty_horizon", 32'(r.empty), 32'(empty_horizon));
          check_field("last_run", 32'(r.last), 32'(last_run));
        end
      end
      if (cfg_we) look_cm = cfg_wdata;
      if (start && !busy) begin
        case (req_type)
          REQ_SEGMENT: begin
            if (entry_index < SEGMENT_SLOTS_DEF) begin
              seg_len[entry_index[SEG_W-1:0]] = length_cm;
              seg_ident[entry_index[SEG_W-1:0]] = ident;
              seg_from[entry_index[SEG_W-1:0]] = from_node;
              seg_to[entry_index[SEG_W-1:0]] = to_node;
            end
          end
          REQ_NODE: begin
            if (entry_index < NODE_SLOTS_DEF) begin
              node_base[entry_index[NODE_W-1:0]] = first_edge;
              node_cnt[entry_index[NODE_W-1:0]] = edge_count;
            end
          end
          REQ_EDGE: begin
            edge_seg[entry_index] = link_segment;
            edge_tgt[entry_index] = to_node;
            edge_fwd[entry_index] = direction_forward;
          end
          REQ_QUERY: trace_horizon(entry_index, direction_forward, offset_cm);
          default: ;
        endcase
      end
    end
    outstanding <= runs_due.size();
  end

endmodule

// File: tb/tb_road_horizon_walker.sv
// ----------------------------------------------------------------------------
// Road horizon walker testbench
// Builds road graphs through table writes, always keeping every entry that a
// walk can reach written, then queries them under several lookahead settings
// and sender idle rates. Chains and rings of segments give long walks, loose
// writes and out-of-range queries add noise. The checker predicts the runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_road_horizon_walker;
  import rhw_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE = 40;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [DIST_W-1:0] cfg_wdata = '0;
  logic              start = 1'b0;
  item_t             beat = '0;
  logic              busy, result_valid, run_forward, empty_horizon, last_run;
  logic [SEG_W-1:0]  run_segment;
  logic [31:0]       run_ident;
  logic [DIST_W-1:0] run_start_cm, run_end_cm;
  int                mismatches, outstanding;

  int idle_pct = 0;
  int items_sent = 0;
  int quiet = 0;

  bit seg_ok [SEGMENT_SLOTS_DEF];
  bit node_ok [NODE_SLOTS_DEF];
  bit edge_ok [EDGE_SLOTS_DEF];
  int seg_pool[$];
  int node_pool[$];
  int edge_pool[$];

  always #10 clk = ~clk;

  road_horizon_walker u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy),
    .req_type(beat.req), .entry_index(beat.idx), .length_cm(beat.length),
    .ident(beat.ident), .from_node(beat.from_node), .to_node(beat.to_node),
    .first_edge(beat.first_edge), .edge_count(beat.edge_count),
    .link_segment(beat.link_segment), .direction_forward(beat.fwd),
    .offset_cm(beat.offset),
    .result_valid(result_valid), .run_segment(run_segment), .run_ident(run_ident),
    .run_start_cm(run_start_cm), .run_end_cm(run_end_cm), .run_forward(run_forward),
    .empty_horizon(empty_horizon), .last_run(last_run)
  );

  rhw_horizon_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy),
    .req_type(beat.req), .entry_index(beat.idx), .length_cm(beat.length),
    .ident(beat.ident), .from_node(beat.from_node), .to_node(beat.to_node),
    .first_edge(beat.first_edge), .edge_count(beat.edge_count),
    .link_segment(beat.link_segment), .direction_forward(beat.fwd),
    .offset_cm(beat.offset),
    .result_valid(result_valid), .run_segment(run_segment), .run_ident(run_ident),
    .run_start_cm(run_start_cm), .run_end_cm(run_end_cm), .run_forward(run_forward),
    .empty_horizon(empty_horizon), .last_run(last_run),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // stall watchdog: no request beat and no result beat for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) quiet <= 0;
    else if (quiet >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else quiet <= quiet + 1;
  end

  function automatic item_t noise_item();
    item_t        it;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    return it;
  endfunction

  task automatic send_beat(item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    beat <= it;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic put_segment(int idx, logic [31:0] len, int from_n, int to_n);
    item_t it;
    it = noise_item();
    it.req = REQ_SEGMENT;
    it.idx = IDX_W'(idx);
    it.length = len;
    it.from_node = NODE_W'(from_n);
    it.to_node = NODE_W'(to_n);
    send_beat(it);
    if (idx < SEGMENT_SLOTS_DEF && !seg_ok[idx]) begin
      seg_ok[idx] = 1;
      seg_pool = {seg_pool, idx};
    end
  endtask

  task automatic put_node(int idx, int base, int cnt);
    item_t it;
    it = noise_item();
    it.req = REQ_NODE;
    it.idx = IDX_W'(idx);
    it.first_edge = IDX_W'(base);
    it.edge_count = CNT_W'(cnt);
    send_beat(it);
    if (idx < NODE_SLOTS_DEF && !node_ok[idx]) begin
      node_ok[idx] = 1;
      node_pool = {node_pool, idx};
    end
  endtask

  task automatic put_edge(int idx, int seg, int tgt, logic dir);
    item_t it;
    it = noise_item();
    it.req = REQ_EDGE;
    it.idx = IDX_W'(idx);
    it.link_segment = SEG_W'(seg);
    it.to_node = NODE_W'(tgt);
    it.fwd = dir;
    send_beat(it);
    if (!edge_ok[idx]) begin
      edge_ok[idx] = 1;
      edge_pool = {edge_pool, idx};
    end
  endtask

  task automatic query(int idx, logic dir, logic [31:0] off);
    item_t it;
    it = noise_item();
    it.req = REQ_QUERY;
    it.idx = IDX_W'(idx);
    it.fwd = dir;
    it.offset = off;
    send_beat(it);
  endtask

  function automatic int any_seg();
    return seg_pool[$urandom_range(0, seg_pool.size() - 1)];
  endfunction

  function automatic int any_node();
    return node_pool[$urandom_range(0, node_pool.size() - 1)];
  endfunction

  function automatic logic [31:0] pick_offset();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return $urandom;
      default: return $urandom_range(0, 60000);
    endcase
  endfunction

  // chain or ring of segments; inner nodes have one way onward unless given an extra random edge
  task automatic build_route(int hops, bit ring, int max_len);
    int nodes[$], segs[$], tsegs[$], tnodes[$], tdirs[$];
    int last_node, base, cnt, s;
    logic [31:0] len;
    for (int i = 0; i <= hops; i++) begin
      if (ring && i == hops) nodes = {nodes, nodes[0]};
      else begin
        nodes = {nodes, int'($urandom_range(0, NODE_SLOTS_DEF - 1))};
        put_node(nodes[i], $urandom, 0);
      end
    end
    for (int i = 0; i < hops; i++) begin
      s = $urandom_range(0, SEGMENT_SLOTS_DEF - 1);
      segs = {segs, s};
      len = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, max_len);
      put_segment(s, len, nodes[i], nodes[i+1]);
    end
    last_node = ring ? hops - 1 : hops;
    for (int j = 0; j <= last_node; j++) begin
      tsegs.delete(); tnodes.delete(); tdirs.delete();
      if (j < hops) begin
        tsegs = {tsegs, segs[j]}; tnodes = {tnodes, nodes[j+1]}; tdirs = {tdirs, 1};
      end
      if (j > 0) begin
        tsegs = {tsegs, segs[j-1]}; tnodes = {tnodes, nodes[j-1]}; tdirs = {tdirs, 0};
      end else if (ring) begin
        tsegs = {tsegs, segs[hops-1]}; tnodes = {tnodes, nodes[hops-1]};
        tdirs = {tdirs, 0};
      end
      if ($urandom_range(0, 7) == 0) begin
        tsegs = {tsegs, any_seg()}; tnodes = {tnodes, any_node()};
        tdirs = {tdirs, int'($urandom_range(0, 1))};
      end
      cnt = tsegs.size();
      base = $urandom_range(0, EDGE_SLOTS_DEF - cnt);
      for (int k = 0; k < cnt; k++)
        put_edge(base + k, tsegs[k], tnodes[k], tdirs[k][0]);
      put_node(nodes[j], base, cnt);
    end
    repeat ($urandom_range(1, 3))
      query(segs[$urandom_range(0, hops - 1)], $urandom_range(0, 1), pick_offset());
  endtask

  task automatic loose_beat();
    int base, cnt, lim;
    case ($urandom_range(0, 7))
      0: put_segment($urandom_range(0, SEGMENT_SLOTS_DEF - 1), $urandom, any_node(), any_node());
      1: put_edge($urandom_range(0, EDGE_SLOTS_DEF - 1), any_seg(), any_node(),
                  $urandom_range(0, 1));
      2: begin
        base = edge_pool[$urandom_range(0, edge_pool.size() - 1)];
        cnt = $urandom_range(0, 15);
        lim = (cnt > MAX_DEGREE_DEF) ? MAX_DEGREE_DEF : cnt;
        for (int k = 0; k < lim; k++)
          if (base + k < EDGE_SLOTS_DEF && !edge_ok[base + k]) begin
            cnt = k;
            break;
          end
        put_node($urandom_range(0, NODE_SLOTS_DEF - 1), base, cnt);
      end
      3: begin
        if ($urandom_range(0, 1)) put_segment($urandom_range(SEGMENT_SLOTS_DEF, 8191),
                                              $urandom, $urandom, $urandom);
        else put_node($urandom_range(NODE_SLOTS_DEF, 8191), $urandom, $urandom);
      end
      4: query($urandom_range(SEGMENT_SLOTS_DEF, 8191), $urandom_range(0, 1), $urandom);
      default: query(any_seg(), $urandom_range(0, 1), pick_offset());
    endcase
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_lookahead(logic [31:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int target, int max_len);
    while (items_sent < target) begin
      if ($urandom_range(0, 2) != 0)
        build_route($urandom_range(2, 8), $urandom_range(0, 2) == 0, max_len);
      else repeat (5) loose_beat();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: default lookahead, then the widest
    put_node(0, 8190, 0);
    put_segment(0, 32'hFFFF_FFFF, 0, 0);
    put_segment(1, 500, 0, 0);
    query(0, 1, 100);
    put_edge(8190, 0, 0, 1);
    put_edge(8191, 1, 0, 0);
    put_node(0, 8190, 4);               // scan runs past the edge table
    query(1, 1, 0);
    query(0, 1, 32'hFFFF_FFFF);         // offset at the segment end
    query(0, 0, 7);
    query(4096, 1, 0);
    query(8191, 0, 32'hFFFF_FFFF);
    put_segment(5000, 1, 2, 3);         // ignored writes
    put_node(8191, 0, 8);
    query(1, 0, 499);
    set_lookahead(32'hFFFF_FFFF);
    query(1, 1, 0);
    query(0, 0, 32'hFFFF_FFFF);
    build_route(3, 1, 1000);            // ring: walk runs out of steps
    query(seg_pool[seg_pool.size() - 1], 1, 0);

    idle_pct = 38;
    set_lookahead(250000);
    random_phase(140, 40000);

    set_lookahead(0);
    random_phase(160, 40000);

    idle_pct = 50;
    set_lookahead($urandom);
    random_phase(250, 2000000);

    idle_pct = 0;
    set_lookahead(32'hFFFF_FFFF);
    random_phase(320, 100000);

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/rhw_pkg.sv
sv/rhw_front.sv
sv/rhw_back.sv
sv/road_horizon_walker.sv
sv/rhw_checker.sv
tb/rhw_horizon_checker.sv
tb/tb_road_horizon_walker.sv
